>>> rtl/dsp_pkg.sv
// Shared constants, types and helpers for the DER ECDSA signature parser.
package dsp_pkg;

   localparam int MAX_SIG_BYTES = 128;
   localparam int ADDR_W        = $clog2(MAX_SIG_BYTES);
   localparam int CNT_W         = $clog2(MAX_SIG_BYTES + 1);
   localparam int SCALAR_BYTES  = 32;
   localparam int BIDX_W        = $clog2(SCALAR_BYTES);

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [6:0] MAX_LEN_BYTES = 7'd4;

   // P-256 group order n.
   localparam logic [255:0] GROUP_ORDER =
      256'hFFFFFFFF00000000_FFFFFFFFFFFFFFFF_BCE6FAADA7179E84_F3B9CAC2FC632551;

   localparam logic [3:0] STAT_OK        = 4'd0;
   localparam logic [3:0] STAT_TRUNC     = 4'd1;
   localparam logic [3:0] STAT_TAG       = 4'd2;
   localparam logic [3:0] STAT_LENFORM   = 4'd3;
   localparam logic [3:0] STAT_TRUNCLEN  = 4'd4;
   localparam logic [3:0] STAT_NONMINLEN = 4'd5;
   localparam logic [3:0] STAT_TRUNCCONT = 4'd6;
   localparam logic [3:0] STAT_TRAIL     = 4'd7;
   localparam logic [3:0] STAT_EMPTY     = 4'd8;
   localparam logic [3:0] STAT_NEG       = 4'd9;
   localparam logic [3:0] STAT_NONMININT = 4'd10;
   localparam logic [3:0] STAT_TRAILSEQ  = 4'd11;
   localparam logic [3:0] STAT_R_RANGE   = 4'd12;
   localparam logic [3:0] STAT_S_RANGE   = 4'd13;
   localparam logic [3:0] STAT_TOOLONG   = 4'd14;

   localparam logic [1:0] PART_SEQ = 2'd0;
   localparam logic [1:0] PART_R   = 2'd1;
   localparam logic [1:0] PART_S   = 2'd2;

   typedef struct packed {
      logic             go;
      logic             too_long;
      logic [CNT_W-1:0] last_pos;
   } parse_cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // Byte k of the group order, most significant first.
   function automatic logic [7:0] order_byte(input logic [BIDX_W-1:0] k);
      logic [255:0] sh;
      sh = GROUP_ORDER << (8 * k);
      return sh[255:248];
   endfunction

endpackage

>>> rtl/dsp_parse_core.sv
// Byte store and parse sequencer: walks the stored signature one byte at a time.
module dsp_parse_core import dsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  parse_cmd_type cmd,
   input  store_wr_type  wr,
   output logic          busy,
   output logic          rsp_valid,
   output logic [3:0]    rsp_status,
   output logic [1:0]    rsp_part,
   output logic [63:0]   rsp_value_word,
   output logic [2:0]    rsp_word_index,
   output logic          rsp_run_end
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_TAG  = 8'b0000_0010,
      ST_LEN1 = 8'b0000_0100,
      ST_LENB = 8'b0000_1000,
      ST_CHK  = 8'b0001_0000,
      ST_INT1 = 8'b0010_0000,
      ST_LOAD = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   logic [7:0] mem [MAX_SIG_BYTES];
   logic [7:0] rdata_ff;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;
   logic stall_ff, stall_in;
   logic [1:0] lvl_ff, lvl_in;
   logic [CNT_W-1:0] pos_ff, pos_in, end_ff, end_in, n_ff, n_in;
   logic [CNT_W-1:0] rstart_ff, rstart_in, rlen_ff, rlen_in;
   logic [CNT_W-1:0] sstart_ff, sstart_in, slen_ff, slen_in;
   logic [31:0] len_ff, len_in;
   logic long_ff, long_in;
   logic [2:0] lencnt_ff, lencnt_in;
   logic [BIDX_W-1:0] k_ff, k_in;
   logic lt_ff, lt_in, gt_ff, gt_in, nz_ff, nz_in;
   logic [255:0] val_ff, val_in, r_ff, r_in;
   logic [2:0] oi_ff, oi_in;

   logic rsp_valid_ff, rsp_valid_in, run_end_ff, run_end_in;
   logic [3:0] status_ff, status_in;
   logic [1:0] part_ff, part_in;
   logic [63:0] word_ff, word_in;
   logic [2:0] idx_ff, idx_in;

   logic err;
   logic [3:0] err_stat;
   logic [1:0] err_part;
   logic int_done;
   logic [CNT_W-1:0] int_start, int_len, int_end;
   logic [CNT_W-1:0] rem, rem1, cur_start, cur_len;
   logic [6:0] lcount;
   logic pad, lt_new, gt_new, nz_new;
   logic [7:0] b, ob;
   logic [255:0] sel;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[pos_ff[ADDR_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;   busy_in = busy_ff;     stall_in = 1'b0;
      lvl_in = lvl_ff;       pos_in = pos_ff;       end_in = end_ff;
      n_in = n_ff;           len_in = len_ff;       long_in = long_ff;
      lencnt_in = lencnt_ff; k_in = k_ff;
      lt_in = lt_ff;         gt_in = gt_ff;         nz_in = nz_ff;
      val_in = val_ff;       r_in = r_ff;           oi_in = oi_ff;
      rstart_in = rstart_ff; rlen_in = rlen_ff;
      sstart_in = sstart_ff; slen_in = slen_ff;
      rsp_valid_in = 1'b0;   status_in = status_ff; part_in = part_ff;
      word_in = word_ff;     idx_in = idx_ff;       run_end_in = run_end_ff;
      err = 1'b0;            err_stat = STAT_OK;    err_part = PART_SEQ;
      int_done = 1'b0;       int_start = pos_ff;    int_len = '0;
      rem = end_ff - pos_ff;
      rem1 = rem - CNT_W'(1);
      lcount = rdata_ff[6:0];
      cur_start = (lvl_ff == PART_R) ? rstart_ff : sstart_ff;
      cur_len = (lvl_ff == PART_R) ? rlen_ff : slen_ff;
      pad = ({{(CNT_W-BIDX_W){1'b0}}, k_ff} < (CNT_W'(SCALAR_BYTES) - cur_len));
      b = pad ? 8'h00 : rdata_ff;
      ob = order_byte(k_ff);
      lt_new = lt_ff | (!lt_ff && !gt_ff && (b < ob));
      gt_new = gt_ff | (!lt_ff && !gt_ff && (b > ob));
      nz_new = nz_ff | (b != 8'h00);
      sel = oi_ff[2] ? val_ff : r_ff;

      if (state_ff == ST_IDLE) begin
         if (cmd.go) begin
            if (cmd.too_long) begin
               err = 1'b1;
               err_stat = STAT_TOOLONG;
            end else begin
               end_in = cmd.last_pos;
               pos_in = '0;
               stall_in = 1'b1;
               lvl_in = PART_SEQ;
               busy_in = 1'b1;
               state_in = ST_TAG;
            end
         end
      end else if (!stall_ff) begin
         case (state_ff)
            ST_TAG: begin
               err_part = lvl_ff;
               if (rem < CNT_W'(2)) begin
                  err = 1'b1;
                  err_stat = STAT_TRUNC;
               end else if (rdata_ff != ((lvl_ff == PART_SEQ) ? TAG_SEQUENCE : TAG_INTEGER))
               begin
                  err = 1'b1;
                  err_stat = STAT_TAG;
               end else begin
                  pos_in = pos_ff + CNT_W'(1);
                  stall_in = 1'b1;
                  state_in = ST_LEN1;
               end
            end
            ST_LEN1: begin
               err_part = lvl_ff;
               pos_in = pos_ff + CNT_W'(1);
               stall_in = 1'b1;
               if (!rdata_ff[7]) begin
                  len_in = {24'h0, rdata_ff};
                  long_in = 1'b0;
                  state_in = ST_CHK;
               end else if (lcount == 7'd0 || lcount > MAX_LEN_BYTES) begin
                  err = 1'b1;
                  err_stat = STAT_LENFORM;
               end else if ({{(32-CNT_W){1'b0}}, rem1} < {25'h0, lcount}) begin
                  err = 1'b1;
                  err_stat = STAT_TRUNCLEN;
               end else begin
                  lencnt_in = lcount[2:0];
                  len_in = '0;
                  long_in = 1'b1;
                  state_in = ST_LENB;
               end
            end
            ST_LENB: begin
               len_in = {len_ff[23:0], rdata_ff};
               pos_in = pos_ff + CNT_W'(1);
               stall_in = 1'b1;
               lencnt_in = lencnt_ff - 3'd1;
               if (lencnt_ff == 3'd1) begin
                  state_in = ST_CHK;
               end
            end
            ST_CHK: begin
               err_part = lvl_ff;
               if (long_ff && len_ff < 32'h80) begin
                  err = 1'b1;
                  err_stat = STAT_NONMINLEN;
               end else if (len_ff > {{(32-CNT_W){1'b0}}, rem}) begin
                  err = 1'b1;
                  err_stat = STAT_TRUNCCONT;
               end else if (lvl_ff == PART_SEQ) begin
                  // The sequence must close exactly at the last stored byte.
                  if (len_ff[CNT_W-1:0] != rem) begin
                     err = 1'b1;
                     err_stat = STAT_TRAIL;
                  end else begin
                     lvl_in = PART_R;
                     state_in = ST_TAG;
                  end
               end else if (len_ff[CNT_W-1:0] == '0) begin
                  err = 1'b1;
                  err_stat = STAT_EMPTY;
               end else if (rdata_ff[7]) begin
                  err = 1'b1;
                  err_stat = STAT_NEG;
               end else if (len_ff[CNT_W-1:0] > CNT_W'(1) && rdata_ff == 8'h00) begin
                  n_in = len_ff[CNT_W-1:0];
                  pos_in = pos_ff + CNT_W'(1);
                  stall_in = 1'b1;
                  state_in = ST_INT1;
               end else begin
                  int_done = 1'b1;
                  int_start = pos_ff;
                  int_len = len_ff[CNT_W-1:0];
               end
            end
            ST_INT1: begin
               err_part = lvl_ff;
               if (!rdata_ff[7]) begin
                  err = 1'b1;
                  err_stat = STAT_NONMININT;
               end else begin
                  int_done = 1'b1;
                  int_start = pos_ff;
                  int_len = n_ff - CNT_W'(1);
               end
            end
            ST_LOAD: begin
               err_part = lvl_ff;
               err_stat = (lvl_ff == PART_R) ? STAT_R_RANGE : STAT_S_RANGE;
               if (cur_len > CNT_W'(SCALAR_BYTES)) begin
                  err = 1'b1;
               end else begin
                  if (!pad) begin
                     pos_in = pos_ff + CNT_W'(1);
                     stall_in = 1'b1;
                  end
                  val_in = {val_ff[247:0], b};
                  lt_in = lt_new;
                  gt_in = gt_new;
                  nz_in = nz_new;
                  k_in = k_ff + BIDX_W'(1);
                  if (k_ff == BIDX_W'(SCALAR_BYTES - 1)) begin
                     if (!(nz_new && lt_new)) begin
                        err = 1'b1;
                     end else if (lvl_ff == PART_R) begin
                        r_in = {val_ff[247:0], b};
                        lvl_in = PART_S;
                        pos_in = sstart_ff;
                        stall_in = 1'b1;
                        k_in = '0;
                        lt_in = 1'b0;
                        gt_in = 1'b0;
                        nz_in = 1'b0;
                     end else begin
                        oi_in = '0;
                        state_in = ST_OUT;
                     end
                  end
               end
            end
            ST_OUT: begin
               rsp_valid_in = 1'b1;
               status_in = STAT_OK;
               part_in = oi_ff[2] ? PART_S : PART_R;
               word_in = sel[64 * (3 - oi_ff[1:0]) +: 64];
               idx_in = oi_ff;
               run_end_in = (oi_ff == 3'd7);
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd7) begin
                  busy_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
               busy_in = 1'b0;
            end
         endcase
      end

      int_end = int_start + int_len;
      if (int_done) begin
         pos_in = int_end;
         stall_in = 1'b1;
         if (lvl_ff == PART_R) begin
            rstart_in = int_start;
            rlen_in = int_len;
            lvl_in = PART_S;
            state_in = ST_TAG;
         end else begin
            sstart_in = int_start;
            slen_in = int_len;
            if (int_end != end_ff) begin
               err = 1'b1;
               err_stat = STAT_TRAILSEQ;
               err_part = PART_SEQ;
            end else begin
               // All encoding checks passed; range-check r, then s.
               lvl_in = PART_R;
               pos_in = rstart_ff;
               k_in = '0;
               lt_in = 1'b0;
               gt_in = 1'b0;
               nz_in = 1'b0;
               state_in = ST_LOAD;
            end
         end
      end

      if (err) begin
         rsp_valid_in = 1'b1;
         status_in = err_stat;
         part_in = err_part;
         word_in = '0;
         idx_in = '0;
         run_end_in = 1'b1;
         busy_in = 1'b0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff <= 1'b0;
         stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         stall_ff <= stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;       pos_ff <= pos_in;       end_ff <= end_in;
      n_ff <= n_in;           len_ff <= len_in;       long_ff <= long_in;
      lencnt_ff <= lencnt_in; k_ff <= k_in;
      lt_ff <= lt_in;         gt_ff <= gt_in;         nz_ff <= nz_in;
      val_ff <= val_in;       r_ff <= r_in;           oi_ff <= oi_in;
      rstart_ff <= rstart_in; rlen_ff <= rlen_in;
      sstart_ff <= sstart_in; slen_ff <= slen_in;
      status_ff <= status_in; part_ff <= part_in;     word_ff <= word_in;
      idx_ff <= idx_in;       run_end_ff <= run_end_in;
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_part = part_ff;
   assign rsp_value_word = word_ff;
   assign rsp_word_index = idx_ff;
   assign rsp_run_end = run_end_ff;

   a_go_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !busy_ff) else $error("parse command while busy");
   a_end_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && run_end_ff |-> !busy_ff) else $error("busy after last word");
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STAT_OK |-> run_end_ff && word_ff == '0 && idx_ff == '0)
      else $error("malformed error word");
   a_out_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> busy_ff) else $error("emitting while idle");

endmodule

>>> rtl/der_ecdsa_signature_parser.sv
// Top level of the DER ECDSA signature parser: byte loading and the parse core.
//
// Usage: present one signature byte on req_data_byte with start high; it is
// taken at a rising edge where busy is low, one byte per cycle. Raise
// req_final_byte with the last byte. The stored signature is then parsed as
// SEQUENCE { INTEGER r, INTEGER s } by a sequencer that reads the byte store
// one byte at a time and range-checks r and s against the P-256 order
// with a byte-wide compare over 32 steps each.
// Results: on success eight words (r then s, most significant first) are
// strobed on rsp_valid in consecutive cycles; on failure a single
// status word is strobed. rsp_run_end marks the last word of a run.
// Busy stays high during the walk, the two range checks and the output. A
// signature over 128 bytes reports too long in the next cycle.
// Reset clears the byte count and the sequencer; the store needs no clearing.
// The receiver cannot stall: each word is valid for exactly one cycle.
module der_ecdsa_signature_parser import dsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_part,
   output logic [63:0] rsp_value_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_run_end
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic accept, room;
   parse_cmd_type cmd;
   store_wr_type wr;

   assign accept = start && !busy;
   assign room = (count_ff < CNT_W'(MAX_SIG_BYTES));

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      wr.en = accept && room;
      wr.addr = count_ff[ADDR_W-1:0];
      wr.data = req_data_byte;
      cmd.go = accept && req_final_byte;
      cmd.too_long = ovf_ff || !room;
      cmd.last_pos = room ? count_ff + CNT_W'(1) : count_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_final_byte) begin
            count_in = '0;
            ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

   dsp_parse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr             (wr),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_part       (rsp_part),
      .rsp_value_word (rsp_value_word),
      .rsp_word_index (rsp_word_index),
      .rsp_run_end    (rsp_run_end)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SIG_BYTES)) else $error("byte count past store size");
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(MAX_SIG_BYTES)) else $error("overflow with room left");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |=> count_ff == '0 && !ovf_ff)
      else $error("store not emptied after final byte");

endmodule
